[hdl/wcs_pkg.sv]
// Package for the weighted cell sampler: sizes, operation and status codes,
// payload word structs, the controller states and the control/status structs.
// Depends on nothing; every other file of the block but wcs_ram uses it.
package wcs_pkg;

    // Table geometry and field masking.
    localparam int ENTRIES     = 4096;
    localparam int REGIONS     = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int ID_BITS     = 24;

    // Fixed field widths of the request and response words.
    localparam int OP_W     = 2;
    localparam int REGION_F = 4;
    localparam int WEIGHT_W = 16;
    localparam int ID_W     = 24;
    localparam int RAND_W   = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 12;

    // Derived internal widths.
    localparam int CUM_W     = 28;
    localparam int ENTRY_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int REGION_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int ADDR_W    = REGION_W + ENTRY_W;
    localparam int TABLE_D   = REGIONS * ENTRIES;
    localparam int SCALED_W  = RAND_W + CUM_W;
    localparam int UPROD_W   = RAND_W + CNT_W;

    localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ?
        {WEIGHT_W{1'b1}} : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [ID_W-1:0] ID_MASK = (ID_BITS >= ID_W) ?
        {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 64'd1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND   = 2'd1;
    localparam logic [OP_W-1:0] OP_WEIGHTED = 2'd2;
    localparam logic [OP_W-1:0] OP_UNIFORM  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [REGION_F-1:0] region;
        logic [WEIGHT_W-1:0] weight;
        logic [ID_W-1:0]     new_cell_id;
        logic [RAND_W-1:0]   random_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [ID_W-1:0]     cell_id;
    } response_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_RESPOND
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic needs_search;
        logic needs_fetch;
        logic search_last;
    } dp_stat_t;

endpackage

[hdl/wcs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; used for the prefix-sum and cell id tables.
module wcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/wcs_ctrl.sv]
// Sequencing controller for the weighted cell sampler.
// Depends on wcs_pkg for the state type and the command/status structs.
module wcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  wcs_pkg::dp_stat_t stat,
    output logic              busy,
    output wcs_pkg::ctrl_cmd_t cmd
);

    wcs_pkg::state_t state_reg;
    wcs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wcs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = wcs_pkg::ST_DECODE;
                end
            end
            wcs_pkg::ST_DECODE:
            begin
                if (stat.needs_search)
                begin
                    state_next = wcs_pkg::ST_SEARCH;
                end
                else if (stat.needs_fetch)
                begin
                    state_next = wcs_pkg::ST_RESPOND;
                end
                else
                begin
                    state_next = wcs_pkg::ST_IDLE;
                end
            end
            wcs_pkg::ST_SEARCH:
            begin
                if (stat.search_last)
                begin
                    state_next = wcs_pkg::ST_RESPOND;
                end
            end
            wcs_pkg::ST_RESPOND:
            begin
                state_next = wcs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            wcs_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            wcs_pkg::ST_DECODE:
            begin
                cmd.exec = 1'b1;
            end
            wcs_pkg::ST_SEARCH:
            begin
                cmd.step = 1'b1;
            end
            wcs_pkg::ST_RESPOND:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[hdl/wcs_datapath.sv]
// Datapath of the weighted cell sampler: request capture, per-region count and
// total registers, the two table RAMs, the scaling multiplier and the search step.
// Depends on wcs_pkg and wcs_ram.
module wcs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  wcs_pkg::request_t   request,
    input  wcs_pkg::ctrl_cmd_t  cmd,
    output wcs_pkg::dp_stat_t   stat,
    output logic                done,
    output wcs_pkg::response_t  response
);

    wcs_pkg::request_t req_reg;

    logic [wcs_pkg::CNT_W-1:0] count_reg [wcs_pkg::REGIONS];
    logic [wcs_pkg::CUM_W-1:0] total_reg [wcs_pkg::REGIONS];

    logic [wcs_pkg::SCALED_W-1:0] scaled_reg;
    logic [wcs_pkg::ENTRY_W-1:0]  lo_reg;
    logic [wcs_pkg::ENTRY_W-1:0]  hi_reg;
    logic [wcs_pkg::ENTRY_W-1:0]  mid_reg;
    logic [wcs_pkg::ENTRY_W-1:0]  idx_reg;
    wcs_pkg::response_t           resp_reg;
    wcs_pkg::response_t           resp_next;
    logic                         done_reg;
    logic                         done_next;

    logic [wcs_pkg::REGION_W-1:0] r_idx;
    logic                         region_ok;
    logic [wcs_pkg::CNT_W-1:0]    n;
    logic [wcs_pkg::CUM_W-1:0]    total;
    logic                         is_append;
    logic                         is_weighted;
    logic                         is_sample;
    logic                         full;
    logic                         nonempty;
    logic [wcs_pkg::ENTRY_W-1:0]  mid0;
    logic [wcs_pkg::UPROD_W-1:0]  uni_prod;
    logic [wcs_pkg::ENTRY_W-1:0]  k_direct;
    logic [wcs_pkg::CUM_W:0]      sum;
    logic [wcs_pkg::CUM_W-1:0]    sum_sat;
    logic [wcs_pkg::ID_W-1:0]     id_masked;

    logic [wcs_pkg::SCALED_W-1:0] cum_scaled;
    logic                         hit;
    logic [wcs_pkg::ENTRY_W-1:0]  lo_next;
    logic [wcs_pkg::ENTRY_W-1:0]  hi_next;
    logic [wcs_pkg::ENTRY_W:0]    mid_sum;
    logic [wcs_pkg::ENTRY_W-1:0]  mid_next;

    logic                         tbl_we;
    logic [wcs_pkg::CNT_W-1:0]    count_next;
    logic [wcs_pkg::CUM_W-1:0]    total_next;
    logic                         ram_we;
    logic [wcs_pkg::ADDR_W-1:0]   ram_waddr;
    logic [wcs_pkg::ADDR_W-1:0]   cum_raddr;
    logic [wcs_pkg::ADDR_W-1:0]   id_raddr;
    logic [wcs_pkg::CUM_W-1:0]    cum_rdata;
    logic [wcs_pkg::ID_W-1:0]     id_rdata;

    // Region-level decode; valid during the decode cycle.
    always_comb
    begin
        r_idx       = wcs_pkg::REGION_W'(req_reg.region);
        region_ok   = 32'(req_reg.region) < wcs_pkg::REGIONS;
        n           = region_ok ? count_reg[r_idx] : '0;
        total       = region_ok ? total_reg[r_idx] : '0;
        is_append   = req_reg.opcode == wcs_pkg::OP_APPEND;
        is_weighted = req_reg.opcode == wcs_pkg::OP_WEIGHTED;
        is_sample   = is_weighted || (req_reg.opcode == wcs_pkg::OP_UNIFORM);
        full        = n >= wcs_pkg::CNT_W'(wcs_pkg::ENTRIES);
        nonempty    = n != '0;
        mid0        = wcs_pkg::ENTRY_W'((n - wcs_pkg::CNT_W'(1)) >> 1);
        uni_prod    = wcs_pkg::UPROD_W'(req_reg.random_value) * wcs_pkg::UPROD_W'(n);
        // The product shifted down is always below n, so no clamp is needed.
        k_direct    = is_weighted ? '0 :
                      wcs_pkg::ENTRY_W'(uni_prod >> wcs_pkg::RAND_W);
        sum         = (wcs_pkg::CUM_W + 1)'(total) +
                      (wcs_pkg::CUM_W + 1)'(req_reg.weight & wcs_pkg::WEIGHT_MASK);
        sum_sat     = sum[wcs_pkg::CUM_W] ? wcs_pkg::CUM_MAX : sum[wcs_pkg::CUM_W-1:0];
        id_masked   = req_reg.new_cell_id & wcs_pkg::ID_MASK;
    end

    // One binary search step per cycle; the read data belongs to mid_reg.
    always_comb
    begin
        cum_scaled = {cum_rdata, {wcs_pkg::RAND_W{1'b0}}};
        hit        = cum_scaled >= scaled_reg;
        lo_next    = hit ? lo_reg : mid_reg + wcs_pkg::ENTRY_W'(1);
        hi_next    = hit ? mid_reg : hi_reg;
        mid_sum    = {1'b0, lo_next} + {1'b0, hi_next};
        mid_next   = mid_sum[wcs_pkg::ENTRY_W:1];
    end

    always_comb
    begin
        stat.needs_search = is_weighted && (n > wcs_pkg::CNT_W'(1));
        stat.needs_fetch  = is_sample && nonempty && !stat.needs_search;
        stat.search_last  = lo_next >= hi_next;
    end

    // Table writes and RAM addressing.
    always_comb
    begin
        tbl_we     = 1'b0;
        count_next = '0;
        total_next = '0;
        ram_we     = 1'b0;
        ram_waddr  = {r_idx, n[wcs_pkg::ENTRY_W-1:0]};
        if (cmd.exec && region_ok)
        begin
            if (req_reg.opcode == wcs_pkg::OP_CLEAR)
            begin
                tbl_we = 1'b1;
            end
            else if (is_append && !full)
            begin
                tbl_we     = 1'b1;
                count_next = n + wcs_pkg::CNT_W'(1);
                total_next = sum_sat;
                ram_we     = 1'b1;
            end
        end
        cum_raddr = cmd.exec ? {r_idx, mid0} : {r_idx, mid_next};
        id_raddr  = cmd.exec ? {r_idx, k_direct} : {r_idx, lo_next};
    end

    // Result word for the cycle it is loaded.
    always_comb
    begin
        resp_next = '0;
        done_next = 1'b0;
        if (cmd.finish)
        begin
            done_next         = 1'b1;
            resp_next.status  = wcs_pkg::STATUS_OK;
            resp_next.index   = wcs_pkg::INDEX_W'(idx_reg);
            resp_next.cell_id = id_rdata;
        end
        else if (cmd.exec && !stat.needs_search && !stat.needs_fetch)
        begin
            done_next = 1'b1;
            if (is_append)
            begin
                if (!region_ok || full)
                begin
                    resp_next.status = wcs_pkg::STATUS_FULL;
                end
                else
                begin
                    resp_next.index   = wcs_pkg::INDEX_W'(n);
                    resp_next.cell_id = id_masked;
                end
            end
            else if (is_sample)
            begin
                resp_next.status = wcs_pkg::STATUS_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wcs_pkg::REGIONS; i++)
            begin
                count_reg[i] <= '0;
                total_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            if (tbl_we)
            begin
                count_reg[r_idx] <= count_next;
                total_reg[r_idx] <= total_next;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.exec)
        begin
            scaled_reg <= wcs_pkg::SCALED_W'(req_reg.random_value) *
                          wcs_pkg::SCALED_W'(total);
            lo_reg     <= '0;
            hi_reg     <= wcs_pkg::ENTRY_W'(n - wcs_pkg::CNT_W'(1));
            mid_reg    <= mid0;
            idx_reg    <= k_direct;
        end
        else if (cmd.step)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
            idx_reg <= lo_next;
        end
        if (done_next)
        begin
            resp_reg <= resp_next;
        end
    end

    wcs_ram #(
        .WIDTH (wcs_pkg::CUM_W),
        .DEPTH (wcs_pkg::TABLE_D)
    ) u_cum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sum_sat),
        .raddr (cum_raddr),
        .rdata (cum_rdata)
    );

    wcs_ram #(
        .WIDTH (wcs_pkg::ID_W),
        .DEPTH (wcs_pkg::TABLE_D)
    ) u_id_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (id_masked),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

    assign done     = done_reg;
    assign response = resp_reg;

endmodule

[hdl/weighted_cell_sampler_core.sv]
// Top level of the weighted cell sampler: per-region weighted sampling tables.
// Depends on wcs_pkg, wcs_ctrl and wcs_datapath.
//
// Usage: a request word is taken at a rising edge with start high and busy low.
// The opcode clears a region, appends a weight and cell id to its prefix-sum
// table, samples an entry by weight, or samples one uniformly.
// Every request gives exactly one response word, shown on response for one
// cycle with done high; the receiver takes it at the edge that ends that cycle
// and cannot hold it off.
// From the accepting edge, clear, append and samples of an empty table are
// answered from the decode state; a uniform sample or a weighted sample of a
// single entry passes through decode and respond; a weighted sample of n
// entries passes through decode, the binary search steps and respond.
// The binary search takes one table RAM read per cycle.
// busy drops in the cycle that done is high, so the next request can be taken
// then.
// Reset clears the per-region entry counts and totals; the table RAMs are not
// cleared, as only entries written since the last clear are ever read.
module weighted_cell_sampler_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wcs_pkg::request_t  request,
    output logic               done,
    output wcs_pkg::response_t response
);

    wcs_pkg::ctrl_cmd_t cmd;
    wcs_pkg::dp_stat_t  stat;

    wcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    wcs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .response (response)
    );

endmodule
